FILE: rtl/mexp_pkg.sv
package mexp_pkg;

    localparam int unsigned DEFAULT_WIDTH = 32;
    localparam int unsigned FIELD_W       = 32;
    localparam int unsigned PC_W          = 4;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_START   = 4'd0;
    localparam pc_t PC_MUL_RED = 4'd3;
    localparam pc_t PC_CHECK_E = 4'd5;
    localparam pc_t PC_MUL_RB  = 4'd7;
    localparam pc_t PC_LD_BB   = 4'd9;
    localparam pc_t PC_MUL_BB  = 4'd10;
    localparam pc_t PC_DONE    = 4'd12;
    localparam pc_t PC_ERR     = 4'd13;
    localparam pc_t PC_UNIT    = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_RED,
        OP_MUL,
        OP_TAKE_B,
        OP_LD_RB,
        OP_TAKE_R,
        OP_LD_BB,
        OP_TAKE_SQ,
        OP_FIN_R,
        OP_FIN_ERR,
        OP_FIN_ZERO
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_MZERO,
        COND_MONE,
        COND_EZERO,
        COND_ELSB0,
        COND_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } mexp_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_mod;
        logic               modulus_zero;
    } mexp_rsp_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            4'd0:    w = '{OP_NOP,      COND_MZERO,  PC_ERR};
            4'd1:    w = '{OP_NOP,      COND_MONE,   PC_UNIT};
            4'd2:    w = '{OP_LD_RED,   COND_NONE,   PC_START};
            4'd3:    w = '{OP_MUL,      COND_MORE,   PC_MUL_RED};
            4'd4:    w = '{OP_TAKE_B,   COND_NONE,   PC_START};
            4'd5:    w = '{OP_NOP,      COND_EZERO,  PC_DONE};
            4'd6:    w = '{OP_LD_RB,    COND_ELSB0,  PC_LD_BB};
            4'd7:    w = '{OP_MUL,      COND_MORE,   PC_MUL_RB};
            4'd8:    w = '{OP_TAKE_R,   COND_NONE,   PC_START};
            4'd9:    w = '{OP_LD_BB,    COND_NONE,   PC_START};
            4'd10:   w = '{OP_MUL,      COND_MORE,   PC_MUL_BB};
            4'd11:   w = '{OP_TAKE_SQ,  COND_ALWAYS, PC_CHECK_E};
            4'd12:   w = '{OP_FIN_R,    COND_NONE,   PC_START};
            4'd13:   w = '{OP_FIN_ERR,  COND_NONE,   PC_START};
            4'd14:   w = '{OP_FIN_ZERO, COND_NONE,   PC_START};
            default: w = '{OP_FIN_ERR,  COND_NONE,   PC_START};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/modular_exponentiation.sv
// Computes base ** exponent mod modulus on one request at a time, with operands taken
// modulo 2**WIDTH. A modulus of zero returns 0 with modulus_zero set; a modulus of one
// returns 0. A short microprogram in a control ROM steps a shared modular multiplier
// that retires one multiplier bit per cycle (double, conditional add, reduce against m
// and 2m). The multiplier loop sets the run time: one multiplication reduces the base at
// the start, then every exponent bit up to the most significant set bit costs a squaring
// and, where the bit is set, a multiplication into the result. A new request is taken
// as soon as the previous result is in the output register.
module modular_exponentiation #(
    parameter int unsigned WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mexp_pkg::mexp_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mexp_pkg::mexp_rsp_t out_data
);

    localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] opnd_t;
    typedef logic [WIDTH+1:0] wide_t;

    opnd_t               b_reg, b_next;
    opnd_t               e_reg, e_next;
    opnd_t               m_reg, m_next;
    opnd_t               r_reg, r_next;
    opnd_t               acc_reg, acc_next;
    opnd_t               mcand_reg, mcand_next;
    opnd_t               mplier_reg, mplier_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    mexp_pkg::pc_t       pc_reg, pc_next;
    logic                busy_reg, busy_next;
    logic                out_valid_reg, out_valid_next;
    mexp_pkg::mexp_rsp_t out_data_reg, out_data_next;

    mexp_pkg::ctrl_t     ctrl;
    wide_t               sum;
    wide_t               m1;
    wide_t               m2;
    opnd_t               mul_res;
    logic                hit;
    logic                fin;
    logic                stall;
    logic                accept;

    assign ctrl     = mexp_pkg::ucode(pc_reg);
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign m1  = {2'b00, m_reg};
    assign m2  = {1'b0, m_reg, 1'b0};
    assign sum = {1'b0, acc_reg, 1'b0} + (mplier_reg[WIDTH-1] ? {2'b00, mcand_reg} : '0);

    always_comb
    begin
        if (sum >= m2)
        begin
            mul_res = WIDTH'(sum - m2);
        end
        else if (sum >= m1)
        begin
            mul_res = WIDTH'(sum - m1);
        end
        else
        begin
            mul_res = WIDTH'(sum);
        end
    end

    always_comb
    begin
        unique case (ctrl.cond)
            mexp_pkg::COND_NONE:   hit = 1'b0;
            mexp_pkg::COND_ALWAYS: hit = 1'b1;
            mexp_pkg::COND_MZERO:  hit = (m_reg == '0);
            mexp_pkg::COND_MONE:   hit = (m_reg == WIDTH'(1));
            mexp_pkg::COND_EZERO:  hit = (e_reg == '0);
            mexp_pkg::COND_ELSB0:  hit = !e_reg[0];
            mexp_pkg::COND_MORE:   hit = (cnt_reg != '0);
            default:               hit = 1'b0;
        endcase
    end

    assign fin = (ctrl.op == mexp_pkg::OP_FIN_R) || (ctrl.op == mexp_pkg::OP_FIN_ERR)
              || (ctrl.op == mexp_pkg::OP_FIN_ZERO);
    assign stall = fin && out_valid_reg && !out_ready;

    always_comb
    begin
        b_next         = b_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (!busy_reg)
        begin
            if (accept)
            begin
                b_next    = WIDTH'(in_data.base);
                e_next    = WIDTH'(in_data.exponent);
                m_next    = WIDTH'(in_data.modulus);
                pc_next   = mexp_pkg::PC_START;
                busy_next = 1'b1;
            end
        end
        else if (!stall)
        begin
            pc_next = hit ? ctrl.target : mexp_pkg::pc_t'(pc_reg + 1'b1);
            unique case (ctrl.op)
                mexp_pkg::OP_NOP:
                begin
                end
                mexp_pkg::OP_LD_RED:
                begin
                    acc_next    = '0;
                    mcand_next  = WIDTH'(1);
                    mplier_next = b_reg;
                    cnt_next    = CNT_W'(WIDTH - 1);
                    r_next      = WIDTH'(1);
                end
                mexp_pkg::OP_MUL:
                begin
                    acc_next    = mul_res;
                    mplier_next = {mplier_reg[WIDTH-2:0], 1'b0};
                    cnt_next    = cnt_reg - 1'b1;
                end
                mexp_pkg::OP_TAKE_B:
                begin
                    b_next = acc_reg;
                end
                mexp_pkg::OP_LD_RB:
                begin
                    acc_next    = '0;
                    mcand_next  = r_reg;
                    mplier_next = b_reg;
                    cnt_next    = CNT_W'(WIDTH - 1);
                end
                mexp_pkg::OP_TAKE_R:
                begin
                    r_next = acc_reg;
                end
                mexp_pkg::OP_LD_BB:
                begin
                    acc_next    = '0;
                    mcand_next  = b_reg;
                    mplier_next = b_reg;
                    cnt_next    = CNT_W'(WIDTH - 1);
                end
                mexp_pkg::OP_TAKE_SQ:
                begin
                    b_next = acc_reg;
                    e_next = e_reg >> 1;
                end
                mexp_pkg::OP_FIN_R:
                begin
                    out_data_next  = '{power_mod: mexp_pkg::FIELD_W'(r_reg), modulus_zero: 1'b0};
                    out_valid_next = 1'b1;
                    busy_next      = 1'b0;
                end
                mexp_pkg::OP_FIN_ERR:
                begin
                    out_data_next  = '{power_mod: '0, modulus_zero: 1'b1};
                    out_valid_next = 1'b1;
                    busy_next      = 1'b0;
                end
                mexp_pkg::OP_FIN_ZERO:
                begin
                    out_data_next  = '{power_mod: '0, modulus_zero: 1'b0};
                    out_valid_next = 1'b1;
                    busy_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= mexp_pkg::PC_START;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        e_reg        <= e_next;
        m_reg        <= m_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.modulus_zero |-> out_data.power_mod == '0)
        else $error("error response carries a nonzero power");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg >= mexp_pkg::PC_CHECK_E && pc_reg <= mexp_pkg::PC_DONE
        |-> r_reg < m_reg && b_reg < m_reg && acc_reg < m_reg)
        else $error("operand not reduced below modulus");

    a_rise_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy_reg) && !busy_reg)
        else $error("response appeared without a finishing step");

endmodule
